// File: hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

	localparam int ByteW = 8;
	localparam int LenW  = 64;
	localparam int KeyW  = 32;

	localparam logic [ByteW-1:0] MaskBit   = 8'h80;
	localparam logic [ByteW-1:0] LenMask   = 8'h7F;
	localparam logic [6:0]       LenCode16 = 7'd126;
	localparam logic [6:0]       LenCode64 = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT     = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] payload_byte;
		logic             last_in_frame;
	} result_t;

	typedef struct packed {
		phase_t phase;
	} status_t;

endpackage

// File: hw/rtl/websocket_frame_deframer_core.sv
// Streaming WebSocket frame deframer: header parse and payload unmasking.
// An accepted word passes from the input register through the decoder into the result register.
// Throughput: one word per cycle while the output side keeps up; a stalled
// result holds the decoder stage, the input register absorbs one more word.
// Header and mask key words give no result. Reset (arst_n low) clears all
// control state; the decoder waits for the first header word.
module websocket_frame_deframer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [wsd_pkg::ByteW-1:0] in_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [wsd_pkg::ByteW-1:0] payload_byte,
	output logic                      last_in_frame
);

	logic                      valid_s1;
	logic [wsd_pkg::ByteW-1:0] byte_s1;
	logic                      slot_free;
	logic                      fire;
	wsd_pkg::result_t          res;
	wsd_pkg::status_t          status;

	assign fire = valid_s1 && slot_free;

	wsd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.advance  (fire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsd_decoder u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.res     (res),
		.status  (status)
	);

	wsd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.slot_free     (slot_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.last_in_frame (last_in_frame)
	);

	// results only come out of the payload phase
	a_res_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> status.phase == wsd_pkg::PH_PAYLOAD)
		else $error("result outside payload phase");

	// closing word of a frame returns the decoder to the first header word
	a_last_to_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last_in_frame |=> status.phase == wsd_pkg::PH_HDR0)
		else $error("frame end did not restart header parse");

	// an accepted word is held in the input register next cycle
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word lost");

	// a decoded result is always loaded into the result register
	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> out_valid && payload_byte == $past(res.payload_byte))
		else $error("result not registered");

endmodule

// File: hw/rtl/wsd_in_reg.sv
// Input register stage: holds one raw word ahead of the decoder.
module wsd_in_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [wsd_pkg::ByteW-1:0] in_byte,
	input  logic                      advance,
	output logic                      valid_s1,
	output logic [wsd_pkg::ByteW-1:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// File: hw/rtl/wsd_decoder.sv
// Frame header state machine and payload unmasking.
module wsd_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [wsd_pkg::ByteW-1:0] byte_s1,
	output wsd_pkg::result_t          res,
	output wsd_pkg::status_t          status
);

	wsd_pkg::phase_t             phase_q, phase_d;
	logic [3:0]                  ext_left_q, ext_left_d;
	logic [wsd_pkg::LenW-1:0]    remain_q, remain_d;
	logic                        mask_on_q, mask_on_d;
	logic [wsd_pkg::KeyW-1:0]    key_q, key_d;
	logic [2:0]                  key_left_q, key_left_d;
	logic [1:0]                  pos_q, pos_d;

	logic [6:0]                  code;
	logic [wsd_pkg::LenW-1:0]    remain_dec;
	logic [wsd_pkg::LenW-1:0]    len_hdr;
	logic [wsd_pkg::ByteW-1:0]   key_byte;

	assign code       = byte_s1[6:0] & wsd_pkg::LenMask[6:0];
	assign remain_dec = remain_q - {{(wsd_pkg::LenW-1){1'b0}}, 1'b1};
	assign key_byte   = key_q[wsd_pkg::KeyW-1 - 8*pos_q -: 8];

	always_comb begin
		phase_d        = phase_q;
		ext_left_d     = ext_left_q;
		remain_d       = remain_q;
		mask_on_d      = mask_on_q;
		key_d          = key_q;
		key_left_d     = key_left_q;
		pos_d          = pos_q;
		len_hdr        = '0;
		res.valid         = 1'b0;
		res.payload_byte  = byte_s1;
		res.last_in_frame = 1'b0;

		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				mask_on_d = (byte_s1 & wsd_pkg::MaskBit) != '0;
				if (code == wsd_pkg::LenCode16) begin
					ext_left_d = 4'd2;
					remain_d   = '0;
					phase_d    = wsd_pkg::PH_EXT;
				end else if (code == wsd_pkg::LenCode64) begin
					ext_left_d = 4'd8;
					remain_d   = '0;
					phase_d    = wsd_pkg::PH_EXT;
				end else begin
					len_hdr  = {{(wsd_pkg::LenW-7){1'b0}}, code};
					remain_d = len_hdr;
					pos_d    = '0;
					if (mask_on_d) begin
						key_left_d = 3'd4;
						key_d      = '0;
						phase_d    = wsd_pkg::PH_KEY;
					end else if (len_hdr != '0) begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end else begin
						phase_d = wsd_pkg::PH_HDR0;
					end
				end
			end
			wsd_pkg::PH_EXT: begin
				remain_d   = {remain_q[wsd_pkg::LenW-9:0], byte_s1};
				ext_left_d = ext_left_q - 4'd1;
				if (ext_left_d == 4'd0) begin
					pos_d = '0;
					if (mask_on_q) begin
						key_left_d = 3'd4;
						key_d      = '0;
						phase_d    = wsd_pkg::PH_KEY;
					end else if (remain_d != '0) begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end else begin
						phase_d = wsd_pkg::PH_HDR0;
					end
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d      = {key_q[wsd_pkg::KeyW-9:0], byte_s1};
				key_left_d = key_left_q - 3'd1;
				if (key_left_d == 3'd0) begin
					phase_d = (remain_q != '0) ? wsd_pkg::PH_PAYLOAD : wsd_pkg::PH_HDR0;
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				res.valid         = 1'b1;
				res.payload_byte  = mask_on_q ? (byte_s1 ^ key_byte) : byte_s1;
				res.last_in_frame = (remain_dec == '0);
				pos_d             = pos_q + 2'd1;
				remain_d          = remain_dec;
				if (remain_dec == '0) begin
					phase_d = wsd_pkg::PH_HDR0;
				end
			end
			default: begin
				// first header byte: flags and opcode are ignored
				phase_d = wsd_pkg::PH_HDR1;
			end
		endcase

		if (!fire) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsd_pkg::PH_HDR0;
			ext_left_q <= '0;
			remain_q   <= '0;
			mask_on_q  <= 1'b0;
			key_q      <= '0;
			key_left_q <= '0;
			pos_q      <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			ext_left_q <= ext_left_d;
			remain_q   <= remain_d;
			mask_on_q  <= mask_on_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			pos_q      <= pos_d;
		end
	end

	assign status.phase = phase_q;

endmodule

// File: hw/rtl/wsd_out_reg.sv
// Result register toward the output channel.
module wsd_out_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wsd_pkg::result_t          res,
	output logic                      slot_free,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [wsd_pkg::ByteW-1:0] payload_byte,
	output logic                      last_in_frame
);

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (slot_free) begin
			out_valid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res.valid) begin
			payload_byte  <= res.payload_byte;
			last_in_frame <= res.last_in_frame;
		end
	end

endmodule
